// ----- hw/rtl/ctbw_pkg.sv -----
package ctbw_pkg;

  localparam int TARGET_W = 256;
  localparam int WORD_W = 64;
  localparam int NWORDS = TARGET_W / WORD_W;
  localparam int IDX_W = $clog2(NWORDS);
  localparam int CNT_W = $clog2(TARGET_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_NEGATIVE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [1:0]          status;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

// ----- hw/rtl/ctbw_front.sv -----
module ctbw_front
  import ctbw_pkg::*;
(
  input  logic [31:0] compact_bits,
  output entry_t      entry
);

  logic [7:0]          size;
  logic [22:0]         mant;
  logic [TARGET_W-1:0] shifted;
  logic [7:0]          shamt;
  logic                ovf;

  always_comb begin
    size = compact_bits[31:24];
    mant = compact_bits[22:0];
    case (size)
      8'd0: mant = 23'd0;
      8'd1: mant = {16'd0, compact_bits[22:16]};
      8'd2: mant = {8'd0, compact_bits[22:8]};
      default: mant = compact_bits[22:0];
    endcase
    shamt = {size[4:0], 3'b000} - 8'd24;
    shifted = {{(TARGET_W-23){1'b0}}, mant} << shamt;
    ovf = (size > 8'd34) || ((mant > 23'h0000ff) && (size > 8'd33)) ||
          ((mant > 23'h00ffff) && (size > 8'd32));
    entry.target = '0;
    if (size <= 8'd3) begin
      entry.target = {{(TARGET_W-23){1'b0}}, mant};
    end else if (size <= 8'd34) begin
      entry.target = shifted;
    end
    if (mant != 23'd0 && compact_bits[23]) begin
      entry.status = ST_NEGATIVE;
    end else if (mant != 23'd0 && ovf) begin
      entry.status = ST_OVERFLOW;
    end else if (mant == 23'd0) begin
      entry.status = ST_ZERO;
    end else begin
      entry.status = ST_VALID;
    end
  end

endmodule

// ----- hw/rtl/ctbw_queue.sv -----
module ctbw_queue
  import ctbw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd,
  output entry_t rd_data,
  output logic   avail
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full = (count == CW'(DEPTH));
  assign avail = (count != '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && avail;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

// ----- hw/rtl/ctbw_back.sv -----
module ctbw_back
  import ctbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_avail,
  input  entry_t            in_entry,
  output logic              in_take,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] work_word,
  output logic [IDX_W-1:0]  word_index,
  output logic              last,
  output logic [1:0]        status
);

  back_state_t         state;
  back_state_t         state_next;
  logic [TARGET_W-1:0] rem;
  logic [TARGET_W-1:0] den;
  logic [TARGET_W-1:0] nq;
  logic [1:0]          cur_status;
  logic [CNT_W-1:0]    cnt;
  logic [TARGET_W:0]   trial;
  logic                ge;
  logic [TARGET_W-1:0] obuf;
  logic                ovalid;
  logic [IDX_W-1:0]    ocnt;
  logic                out_free;
  logic                load_out;
  logic                pop_ok;

  assign trial = {rem, nq[TARGET_W-1]};
  assign ge = trial >= {1'b0, den};
  assign pop_ok = pop && ovalid;
  assign out_free = !ovalid || (pop_ok && ocnt == IDX_W'(NWORDS - 1));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (in_avail) begin
          state_next = (in_entry.status == ST_VALID) ? BK_DIV : BK_FIN;
        end
      end
      BK_DIV: begin
        if (cnt == CNT_W'(TARGET_W - 1)) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    in_take = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: in_take = in_avail;
      BK_FIN: load_out = out_free;
      default: begin
        in_take = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      ovalid <= 1'b0;
      ocnt <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        ovalid <= 1'b1;
        ocnt <= '0;
      end else if (pop_ok) begin
        ocnt <= ocnt + 1'b1;
        if (ocnt == IDX_W'(NWORDS - 1)) begin
          ovalid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rem <= '0;
      nq <= ~in_entry.target;
      den <= in_entry.target + 1'b1;
      cur_status <= in_entry.status;
      cnt <= '0;
    end else if (state == BK_DIV) begin
      rem <= ge ? TARGET_W'(trial - {1'b0, den}) : trial[TARGET_W-1:0];
      nq <= {nq[TARGET_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
    if (load_out) begin
      obuf <= (cur_status == ST_VALID) ? nq + 1'b1 : '0;
      status <= cur_status;
    end
  end

  assign empty = !ovalid;
  assign work_word = obuf[ocnt*WORD_W +: WORD_W];
  assign word_index = ocnt;
  assign last = (ocnt == IDX_W'(NWORDS - 1));

endmodule

// ----- hw/rtl/compact_target_block_work_top.sv -----
// Each compact target yields four result beats, one 64-bit work slice each.
// A valid target passes through the queue, then the radix-2 restoring divider,
// and its result is then loaded into the output buffer, from which the beats
// are popped. The divider works on one target at a time; further targets wait
// in the queue. An invalid target skips the divider, and its four beats are
// zero, one beat per pop.
// Synchronous active-high reset empties the queue and the result buffer.
module compact_target_block_work_top
  import ctbw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [31:0]       compact_bits,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] work_word,
  output logic [IDX_W-1:0]  word_index,
  output logic              last,
  output logic [1:0]        status
);

  entry_t dec_entry;
  entry_t q_entry;
  logic   q_avail;
  logic   q_take;

  ctbw_front u_front (
    .compact_bits(compact_bits),
    .entry(dec_entry)
  );

  ctbw_queue #(.DEPTH(DEPTH)) u_queue (
    .clk(clk),
    .rst(rst),
    .wr(push),
    .wr_data(dec_entry),
    .full(full),
    .rd(q_take),
    .rd_data(q_entry),
    .avail(q_avail)
  );

  ctbw_back u_back (
    .clk(clk),
    .rst(rst),
    .in_avail(q_avail),
    .in_entry(q_entry),
    .in_take(q_take),
    .empty(empty),
    .pop(pop),
    .work_word(work_word),
    .word_index(word_index),
    .last(last),
    .status(status)
  );

`ifndef SYNTHESIS
  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    empty |-> word_index == '0) else $error("index not reset while empty");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_VALID) |-> work_word == '0)
    else $error("nonzero work for invalid target");
  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> !empty) else $error("run cut short");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> word_index == $past(word_index) + 1'b1)
    else $error("beat index skipped");
`endif

endmodule

// ----- verif/tb_compact_target_block_work_top.sv -----
module tb_compact_target_block_work_top;
  import ctbw_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    logic              lst;
    logic [1:0]        stat;
  } work_beat_t;

  class work_scoreboard;
    work_beat_t pending[$];
    int errors;
    int beats_checked;
    int valid_targets;
    int invalid_targets;

    function new();
      errors = 0;
      beats_checked = 0;
      valid_targets = 0;
      invalid_targets = 0;
    endfunction

    function void note_target(logic [31:0] bits);
      logic [7:0]     size;
      logic [22:0]    mant;
      logic [1:0]     stat;
      logic [255:0]   tgt;
      logic [256:0]   quot;
      logic [255:0]   work;
      work_beat_t     b;
      size = bits[31:24];
      mant = bits[22:0];
      stat = ST_VALID;
      tgt = '0;
      work = '0;
      if (size <= 3) mant = mant >> (8 * (3 - size));
      if (mant != 0 && bits[23]) begin
        stat = ST_NEGATIVE;
      end else if (mant != 0 && (size > 34 || (mant > 23'hff && size > 33) ||
                                 (mant > 23'hffff && size > 32))) begin
        stat = ST_OVERFLOW;
      end else begin
        if (size <= 3) tgt = 256'(mant);
        else if (size <= 34) tgt = 256'(mant) << (8 * (size - 3));
        if (tgt == '0) stat = ST_ZERO;
      end
      if (stat == ST_VALID) begin
        quot = (257'd1 << 256) / ({1'b0, tgt} + 257'd1);
        work = quot[255:0];
        valid_targets++;
      end else begin
        invalid_targets++;
      end
      for (int k = 0; k < NWORDS; k++) begin
        b.word = work[k*WORD_W +: WORD_W];
        b.idx = IDX_W'(k);
        b.lst = (k == NWORDS - 1);
        b.stat = stat;
        pending.push_back(b);
      end
    endfunction

    function void check_beat(logic [WORD_W-1:0] w, logic [IDX_W-1:0] i, logic l,
                             logic [1:0] s);
      work_beat_t e;
      beats_checked++;
      if (pending.size() == 0) begin
        $error("unexpected beat: work_word %h word_index %0d", w, i);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w !== e.word) begin
        $error("work_word expected %h actual %h", e.word, w);
        errors++;
      end
      if (i !== e.idx) begin
        $error("word_index expected %0d actual %0d", e.idx, i);
        errors++;
      end
      if (l !== e.lst) begin
        $error("last expected %0d actual %0d", e.lst, l);
        errors++;
      end
      if (s !== e.stat) begin
        $error("status expected %0d actual %0d", e.stat, s);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [31:0]       compact_bits = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [WORD_W-1:0] work_word;
  logic [IDX_W-1:0]  word_index;
  logic              last;
  logic [1:0]        status;

  work_scoreboard sb = new();
  int phase = 0;
  int targets_in = 0;
  int quiet_cycles = 0;
  bit held = 0;
  bit sending_done = 0;
  logic [31:0] targets[$];

  compact_target_block_work_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .compact_bits(compact_bits),
    .empty(empty), .pop(pop), .work_word(work_word), .word_index(word_index),
    .last(last), .status(status)
  );

  always #5 clk = ~clk;

  function automatic int send_idle_pct(int p);
    return (p == 1) ? 62 : (p == 3) ? 28 : 0;
  endfunction

  function automatic int recv_stall_pct(int p);
    return (p == 2) ? 62 : (p == 3) ? 28 : 0;
  endfunction

  function automatic logic [31:0] random_target();
    logic [7:0]  size;
    logic [22:0] mant;
    logic        sgn;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      size = (r < 5) ? 8'($urandom_range(0, 34)) : 8'($urandom_range(30, 36));
      mant = 23'($urandom);
      if ($urandom_range(0, 3) == 0) mant = mant >> $urandom_range(0, 22);
      sgn = ($urandom_range(0, 9) == 0);
      return {size, sgn, mant};
    end
    return $urandom;
  endfunction

  task automatic send_target(logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct(phase)) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    compact_bits <= v;
    do @(posedge clk); while (!(push && !full));
    sb.note_target(v);
    targets_in++;
  endtask

  initial begin
    targets = '{32'h0000_0000, 32'hffff_ffff, 32'h1d00_ffff, 32'h0300_0001,
                32'h0200_00ff, 32'h0200_8000, 32'h0100_7fff, 32'h0001_2345,
                32'h0080_0000, 32'h0380_0001, 32'h0480_0000, 32'h2200_00ff,
                32'h2200_0100, 32'h2100_ffff, 32'h2101_0000, 32'h2000_ffff,
                32'h207f_ffff, 32'h2300_0001, 32'h2380_0001, 32'hff00_0000,
                32'h2300_0000, 32'h0400_0001, 32'h0480_0001, 32'h017f_ffff};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    foreach (targets[n]) send_target(targets[n]);
    for (int n = 0; n < 480; n++) begin
      phase = (n * 4) / 480;
      send_target(random_target());
    end
    @(negedge clk);
    push <= 1'b0;
    sending_done = 1;
  end

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && targets_in >= 12) begin
        held = 1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct(phase));
      @(posedge clk);
      if (pop && !empty) sb.check_beat(work_word, word_index, last, status);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    wait (sb.pending.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d targets sent (%0d valid, %0d invalid), %0d beats checked",
             targets_in, sb.valid_targets, sb.invalid_targets, sb.beats_checked);
    $display("phases: free flow, sender gaps, receiver stalls, both, one long hold");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
